FILE: design/hsvhr_pkg.sv
// hsvhr_pkg: types and constants shared by the hue rotator stages
// no dependencies; compiled first

package hsvhr_pkg;

    // channel that holds the largest value, red wins ties, then green
    localparam logic [1:0] HUE_BASE_R = 2'd0;
    localparam logic [1:0] HUE_BASE_G = 2'd1;
    localparam logic [1:0] HUE_BASE_B = 2'd2;

    // sextant codes, hue / 60
    localparam logic [2:0] SEXT_R_TO_Y = 3'd0;
    localparam logic [2:0] SEXT_Y_TO_G = 3'd1;
    localparam logic [2:0] SEXT_G_TO_C = 3'd2;
    localparam logic [2:0] SEXT_C_TO_B = 3'd3;
    localparam logic [2:0] SEXT_B_TO_M = 3'd4;
    localparam logic [2:0] SEXT_M_TO_R = 3'd5;

    localparam int unsigned ROT_W      = 10;
    localparam logic [ROT_W-1:0] ROT_RESET = 10'd36;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

    typedef struct packed {
        logic [31:0] pixel;
        logic        grey;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [7:0]  chroma;
    } t_pix_info;

    // divider work item: numerator remainder and quotient bits so far
    typedef struct packed {
        t_pix_info   info;
        logic        neg;
        logic [1:0]  base;
        logic [13:0] part;
        logic [5:0]  quot;
    } t_div;

    typedef struct packed {
        t_pix_info   info;
        logic [8:0]  hue;
    } t_hue_wrap;

    typedef struct packed {
        t_pix_info   info;
        logic [2:0]  sext;
        logic [5:0]  rem;
    } t_hue;

endpackage

FILE: design/hsvhr_in_if.sv
// hsvhr_in_if: valid/ready channel carrying one input pixel item
// no dependencies

interface hsvhr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] color_in;

    modport source (output valid, output color_in, input ready);
    modport sink   (input valid, input color_in, output ready);
endinterface

FILE: design/hsvhr_out_if.sv
// hsvhr_out_if: valid/ready channel carrying one rotated pixel item
// no dependencies

interface hsvhr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] color_out;

    modport source (output valid, output color_out, input ready);
    modport sink   (input valid, input color_out, output ready);
endinterface

FILE: design/hsvhr_analyze.sv
// hsvhr_analyze: first stage, max/min/chroma and the hue numerator
// depends on hsvhr_pkg

module hsvhr_analyze
    import hsvhr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_pixel,
    output logic        o_valid,
    output t_div        o_data
);

    logic [7:0] r, g, b, hi, lo, chroma;
    logic [8:0] diff;
    logic [7:0] mag;
    logic       neg;
    logic [1:0] base;
    logic [13:0] num;
    logic       r_valid;
    t_div       r_data;
    t_div       n_data;

    always_comb begin
        r = i_pixel[23:16];
        g = i_pixel[15:8];
        b = i_pixel[7:0];
        hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        lo = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        chroma = hi - lo;
        if (hi == r) begin
            base = HUE_BASE_R;
            diff = {1'b0, g} - {1'b0, b};
        end else if (hi == g) begin
            base = HUE_BASE_G;
            diff = {1'b0, b} - {1'b0, r};
        end else begin
            base = HUE_BASE_B;
            diff = {1'b0, r} - {1'b0, g};
        end
        neg = diff[8];
        mag = neg ? 8'(-diff) : diff[7:0];
        // 60 * mag as 64 * mag - 4 * mag
        num = ({mag, 6'd0}) - ({4'd0, mag, 2'd0});

        n_data.info.pixel  = i_pixel;
        n_data.info.grey   = (chroma == 8'd0);
        n_data.info.hi     = hi;
        n_data.info.lo     = lo;
        n_data.info.chroma = chroma;
        n_data.neg         = neg;
        n_data.base        = base;
        n_data.part        = num;
        n_data.quot        = 6'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/hsvhr_div.sv
// hsvhr_div: two-stage restoring divider, 60*|diff| / chroma, three bits per stage
// depends on hsvhr_pkg

module hsvhr_div
    import hsvhr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_data,
    output logic o_valid,
    output t_div o_data
);

    t_div r_hi_data, r_lo_data;
    t_div n_hi_data, n_lo_data;
    logic r_hi_valid, r_lo_valid;

    // quotient never exceeds 60, so six bits cover it; bits 5..3 then 2..0
    always_comb begin
        logic [13:0] dvs;
        n_hi_data = i_data;
        for (int i = 0; i < 3; i++) begin
            dvs = 14'(i_data.info.chroma) << (5 - i);
            if (n_hi_data.part >= dvs) begin
                n_hi_data.part = n_hi_data.part - dvs;
                n_hi_data.quot[5 - i] = 1'b1;
            end
        end
    end

    always_comb begin
        logic [13:0] dvs;
        n_lo_data = r_hi_data;
        for (int i = 0; i < 3; i++) begin
            dvs = 14'(r_hi_data.info.chroma) << (2 - i);
            if (n_lo_data.part >= dvs) begin
                n_lo_data.part = n_lo_data.part - dvs;
                n_lo_data.quot[2 - i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_valid <= 1'b0;
            r_lo_valid <= 1'b0;
        end else if (i_en) begin
            r_hi_valid <= i_valid;
            r_lo_valid <= r_hi_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi_data <= n_hi_data;
            r_lo_data <= n_lo_data;
        end
    end

    assign o_valid = r_lo_valid;
    assign o_data  = r_lo_data;

endmodule

FILE: design/hsvhr_hue.sv
// hsvhr_hue: hue offset, rotation, wrap into 0..359, then sextant and remainder
// depends on hsvhr_pkg

module hsvhr_hue
    import hsvhr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic signed [ROT_W-1:0] i_rot,
    input  logic             i_valid,
    input  t_div             i_data,
    output logic             o_valid,
    output t_hue             o_data
);

    logic signed [10:0] offset, qs, sum, wrapped;
    t_hue_wrap r_wrap, n_wrap;
    t_hue      r_hue, n_hue;
    logic      r_wrap_valid, r_hue_valid;

    always_comb begin
        case (i_data.base)
            HUE_BASE_R: offset = 11'sd0;
            HUE_BASE_G: offset = 11'sd120;
            HUE_BASE_B: offset = 11'sd240;
            default:    offset = 11'sd0;
        endcase
        qs  = i_data.neg ? -$signed({5'd0, i_data.quot}) : $signed({5'd0, i_data.quot});
        sum = offset + qs + 11'(i_rot);
        // sum stays within -572..811
        if (sum < 11'sd0) begin
            if (sum < -11'sd360) begin
                wrapped = sum + 11'sd720;
            end else begin
                wrapped = sum + 11'sd360;
            end
        end else if (sum >= 11'sd720) begin
            wrapped = sum - 11'sd720;
        end else if (sum >= 11'sd360) begin
            wrapped = sum - 11'sd360;
        end else begin
            wrapped = sum;
        end
        n_wrap.info = i_data.info;
        n_wrap.hue  = wrapped[8:0];
    end

    always_comb begin
        logic [8:0] base60;
        n_hue.info = r_wrap.info;
        if (r_wrap.hue >= 9'd300) begin
            n_hue.sext = SEXT_M_TO_R;
            base60     = 9'd300;
        end else if (r_wrap.hue >= 9'd240) begin
            n_hue.sext = SEXT_B_TO_M;
            base60     = 9'd240;
        end else if (r_wrap.hue >= 9'd180) begin
            n_hue.sext = SEXT_C_TO_B;
            base60     = 9'd180;
        end else if (r_wrap.hue >= 9'd120) begin
            n_hue.sext = SEXT_G_TO_C;
            base60     = 9'd120;
        end else if (r_wrap.hue >= 9'd60) begin
            n_hue.sext = SEXT_Y_TO_G;
            base60     = 9'd60;
        end else begin
            n_hue.sext = SEXT_R_TO_Y;
            base60     = 9'd0;
        end
        n_hue.rem = 6'(r_wrap.hue - base60);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_valid <= 1'b0;
            r_hue_valid  <= 1'b0;
        end else if (i_en) begin
            r_wrap_valid <= i_valid;
            r_hue_valid  <= r_wrap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wrap <= n_wrap;
            r_hue  <= n_hue;
        end
    end

    assign o_valid = r_hue_valid;
    assign o_data  = r_hue;

endmodule

FILE: design/hsvhr_rebuild.sv
// hsvhr_rebuild: q/t terms via multiply by reciprocal of 60, rgb assembly
// depends on hsvhr_pkg

module hsvhr_rebuild
    import hsvhr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_hue        i_data,
    output logic        o_valid,
    output logic [31:0] o_color
);

    // floor(x / 60) == (x * 17477) >> 20 for x up to 255 * 60
    localparam logic [14:0] DIV60_MUL   = 15'd17477;
    localparam int unsigned DIV60_SHIFT = 20;

    typedef struct packed {
        t_pix_info   info;
        logic [2:0]  sext;
        logic [13:0] prod_fall;
        logic [13:0] prod_rise;
    } t_prod;

    typedef struct packed {
        t_pix_info   info;
        logic [2:0]  sext;
        logic [7:0]  q_fall;
        logic [7:0]  q_rise;
    } t_quot;

    t_prod       r_prod, n_prod;
    t_quot       r_quot, n_quot;
    logic [31:0] r_color, n_color;
    logic        r_prod_valid, r_quot_valid, r_color_valid;
    logic [28:0] wide_fall, wide_rise;
    logic [7:0]  fall, rise, hi, lo, red, grn, blu;

    always_comb begin
        n_prod.info      = i_data.info;
        n_prod.sext      = i_data.sext;
        n_prod.prod_fall = {6'd0, i_data.info.chroma} * {8'd0, i_data.rem};
        n_prod.prod_rise = {6'd0, i_data.info.chroma} * {8'd0, 6'd60 - i_data.rem};
    end

    always_comb begin
        wide_fall = {15'd0, r_prod.prod_fall} * {14'd0, DIV60_MUL};
        wide_rise = {15'd0, r_prod.prod_rise} * {14'd0, DIV60_MUL};
        n_quot.info   = r_prod.info;
        n_quot.sext   = r_prod.sext;
        n_quot.q_fall = wide_fall[DIV60_SHIFT+7:DIV60_SHIFT];
        n_quot.q_rise = wide_rise[DIV60_SHIFT+7:DIV60_SHIFT];
    end

    always_comb begin
        hi   = r_quot.info.hi;
        lo   = r_quot.info.lo;
        fall = hi - r_quot.q_fall;
        rise = hi - r_quot.q_rise;
        case (r_quot.sext)
            SEXT_R_TO_Y: begin red = hi;   grn = rise; blu = lo;   end
            SEXT_Y_TO_G: begin red = fall; grn = hi;   blu = lo;   end
            SEXT_G_TO_C: begin red = lo;   grn = hi;   blu = rise; end
            SEXT_C_TO_B: begin red = lo;   grn = fall; blu = hi;   end
            SEXT_B_TO_M: begin red = rise; grn = lo;   blu = hi;   end
            default:     begin red = hi;   grn = lo;   blu = fall; end
        endcase
        // grey pixels pass through untouched, alpha included
        n_color = r_quot.info.grey ? r_quot.info.pixel : {ALPHA_OPAQUE, red, grn, blu};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid  <= 1'b0;
            r_quot_valid  <= 1'b0;
            r_color_valid <= 1'b0;
        end else if (i_en) begin
            r_prod_valid  <= i_valid;
            r_quot_valid  <= r_prod_valid;
            r_color_valid <= r_quot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_quot  <= n_quot;
            r_color <= n_color;
        end
    end

    assign o_valid = r_color_valid;
    assign o_color = r_color;

endmodule

FILE: design/hsv_hue_rotator.sv
// hsv_hue_rotator: top level of the ARGB hue rotation pipeline
// depends on hsvhr_pkg, hsvhr_in_if, hsvhr_out_if and the hsvhr_* stage modules
//
// usage
//   i_pix carries one ARGB pixel item (color_in), o_pix the rotated pixel (color_out).
//   i_cfg_wr_en / i_cfg_wr_data write the signed rotation in degrees; write it
//   only while no item is in flight.
//   the hue is rebuilt from max-channel sextant math with integer truncation;
//   value and chroma are kept, grey pixels pass through unchanged with their alpha,
//   every other result has alpha 255.
// order and throughput
//   an item passes the analysis, divider, hue and rebuild registers in that order.
//   one item per cycle sustained while the output is not stalled; the divider takes
//   three quotient bits per stage, so the whole pipeline advances as one.
// reset
//   all stage valid bits clear, the rotation returns to 36 degrees.
// stall
//   when the output holds an item that the receiver does not take, every stage
//   freezes and i_pix.ready drops; nothing is lost or repeated. empty slots let
//   the pipe keep filling as long as the output register is free.

module hsv_hue_rotator
    import hsvhr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic signed [ROT_W-1:0] i_cfg_wr_data,
    hsvhr_in_if.sink                i_pix,
    hsvhr_out_if.source             o_pix
);

    logic signed [ROT_W-1:0] r_rot;
    logic                    adv;      // whole pipeline moves one step
    logic                    ana_valid, div_valid, hue_valid, out_valid;
    t_div                    ana_data, div_data;
    t_hue                    hue_data;
    logic [31:0]             out_color;

    // rotation register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= ROT_RESET;
        end else if (i_cfg_wr_en) begin
            r_rot <= i_cfg_wr_data;
        end
    end

    // move on unless the output register holds an item not yet taken
    assign adv         = !out_valid || o_pix.ready;
    assign i_pix.ready = adv;

    // max, min, chroma and 60*|difference|
    hsvhr_analyze u_analyze (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_pix.valid),
        .i_pixel (i_pix.color_in),
        .o_valid (ana_valid),
        .o_data  (ana_data)
    );

    // truncating divide by chroma
    hsvhr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (ana_valid),
        .i_data  (ana_data),
        .o_valid (div_valid),
        .o_data  (div_data)
    );

    // rotate, wrap, split into sextant and remainder
    hsvhr_hue u_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_rot   (r_rot),
        .i_valid (div_valid),
        .i_data  (div_data),
        .o_valid (hue_valid),
        .o_data  (hue_data)
    );

    // q/t terms and rgb rebuild; its last register is the output register
    hsvhr_rebuild u_rebuild (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (hue_valid),
        .i_data  (hue_data),
        .o_valid (out_valid),
        .o_color (out_color)
    );

    assign o_pix.valid     = out_valid;
    assign o_pix.color_out = out_color;

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for hsv_hue_rotator, directed and random pixel items
// depends on hsvhr_pkg, hsvhr_in_if, hsvhr_out_if and the hsv_hue_rotator design
`timescale 1ns / 1ps

module tb_top;
    import hsvhr_pkg::*;

    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int SETTLE       = 16;     // extra wait after the pipe is empty
    localparam int ITEMS_PER_PH = 75;     // random items in each rotation phase

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic signed [ROT_W-1:0] i_cfg_wr_data;

    hsvhr_in_if  pix_in ();
    hsvhr_out_if pix_out ();

    hsv_hue_rotator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pix         (pix_in),
        .o_pix         (pix_out)
    );

    logic [31:0]             pixel_q[$];    // pixels waiting to be offered
    logic [31:0]             rotated_q[$];  // predicted output pixels, oldest first
    logic signed [ROT_W-1:0] rot_deg;       // bench copy of the rotation register
    int                      err_cnt;
    bit                      idle_on;       // random gaps on both sides
    bit                      hold_go;       // starts the long receiver hold-off
    logic                    rx_hold;

    // clock, 4 ns period
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // every input known from time zero
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        pix_in.valid    = 1'b0;
        pix_in.color_in = '0;
        pix_out.ready   = 1'b0;
        err_cnt         = 0;
        idle_on         = 1'b1;
        hold_go         = 1'b0;
    end

    // expected pixel for one input at a given rotation
    // hue from the largest channel, integer division truncating toward zero,
    // then rebuilt from the sextant and the remainder inside it
    function automatic logic [31:0] rotate_hue(logic [31:0] px, logic signed [ROT_W-1:0] deg);
        int r, g, b, hi, lo, chroma, hue, rem, fall, rise;
        logic [2:0] sext;
        r = px[23:16];
        g = px[15:8];
        b = px[7:0];
        hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        lo = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        chroma = hi - lo;
        // grey keeps everything, alpha too
        if (chroma == 0)
            return px;
        // red wins a tie for largest, then green
        if (hi == r)
            hue = (60 * (g - b)) / chroma;
        else if (hi == g)
            hue = 120 + (60 * (b - r)) / chroma;
        else
            hue = 240 + (60 * (r - g)) / chroma;
        // wrap into 0..359, any 10-bit rotation allowed
        hue  = ((hue + int'(deg)) % 360 + 360) % 360;
        sext = 3'(hue / 60);
        rem  = hue % 60;
        fall = hi - (chroma * rem) / 60;
        rise = hi - (chroma * (60 - rem)) / 60;
        case (sext)
            SEXT_R_TO_Y: begin r = hi;   g = rise; b = lo;   end
            SEXT_Y_TO_G: begin r = fall; g = hi;   b = lo;   end
            SEXT_G_TO_C: begin r = lo;   g = hi;   b = rise; end
            SEXT_C_TO_B: begin r = lo;   g = fall; b = hi;   end
            SEXT_B_TO_M: begin r = rise; g = lo;   b = hi;   end
            default:     begin r = hi;   g = lo;   b = fall; end
        endcase
        return {ALPHA_OPAQUE, 8'(r), 8'(g), 8'(b)};
    endfunction

    // sender: keeps valid up across back-to-back items, holds the pixel while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else if (!pix_in.valid || pix_in.ready) begin
            if (pixel_q.size() != 0 && !(idle_on && $urandom_range(99) < 25)) begin
                pix_in.color_in <= pixel_q.pop_front();
                pix_in.valid    <= 1'b1;
            end else begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    // receiver, rotation copy, prediction on input accept, check on output accept
    always @(posedge i_clk) begin : monitor_p
        logic [31:0] want;
        if (!i_rst_n) begin
            rot_deg       <= ROT_RESET;
            pix_out.ready <= 1'b0;
        end else begin
            if (i_cfg_wr_en)
                rot_deg <= i_cfg_wr_data;
            if (pix_in.valid && pix_in.ready)
                rotated_q.push_back(rotate_hue(pix_in.color_in, rot_deg));
            if (pix_out.valid && pix_out.ready) begin
                if (rotated_q.size() == 0) begin
                    $error("color_out: no item expected, got %08h", pix_out.color_out);
                    err_cnt++;
                end else begin
                    want = rotated_q.pop_front();
                    if (pix_out.color_out !== want) begin
                        $error("color_out: expected %08h, got %08h", want, pix_out.color_out);
                        err_cnt++;
                    end
                end
            end
            pix_out.ready <= !rx_hold && !(idle_on && $urandom_range(99) < 25);
        end
    end

    // long receiver hold-off, counted here so the sender keeps offering meanwhile
    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // safety net against a hung handshake
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // stimulus: directed pixels at the reset rotation, then one phase per rotation
    initial begin : stim_p
        logic [31:0] directed[20];
        int          rot_list[14];
        int          lo, m, pick;
        logic [7:0]  c0, c1, c2;
        logic [7:0]  alpha;

        directed = '{
            32'h00000000, 32'hffffffff, 32'h5a808080,     // grey, alpha kept
            32'h00ff0000, 32'h0000ff00, 32'h000000ff,     // primaries
            32'h80ffff00, 32'h0000ffff, 32'h00ff00ff,     // ties for largest
            32'h00ff0001, 32'h00ff0080,                   // red largest, negative hue
            32'h00010000, 32'h00fffffe, 32'h00fe00ff,     // chroma of one, then full chroma
            32'h7f00ff80, 32'h0080ff00, 32'h00ff8000,
            32'h00123456, 32'hff654321, 32'h01fe01fe
        };
        // extremes of the register and of the legal range, then random values
        rot_list = '{0, 360, -360, 511, -512, -1, 1, 180, -180, 59, 300, 0, 0, 0};
        for (int k = 11; k < 14; k++)
            rot_list[k] = int'($signed(10'($urandom_range(1023))));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        foreach (directed[k])
            pixel_q.push_back(directed[k]);

        for (int ph = 0; ph <= $size(rot_list); ph++) begin
            // idle: everything sent, everything back, pipe empty
            @(negedge i_clk);
            while (pixel_q.size() != 0 || pix_in.valid || rotated_q.size() != 0)
                @(negedge i_clk);
            repeat (SETTLE) @(negedge i_clk);
            if (ph == $size(rot_list))
                break;

            @(posedge i_clk);
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= 10'(rot_list[ph]);
            @(posedge i_clk);
            i_cfg_wr_en   <= 1'b0;
            @(negedge i_clk);

            // one phase runs without any gaps and with the long hold-off on top
            idle_on = (ph != 3);

            for (int n = 0; n < ITEMS_PER_PH + ((ph == 3) ? 40 : 0); n++) begin
                alpha = 8'($urandom);
                case ($urandom_range(9))
                    6, 7: begin
                        // near grey, small chroma
                        lo = $urandom_range(250);
                        c0 = 8'(lo + $urandom_range(5));
                        c1 = 8'(lo + $urandom_range(5));
                        c2 = 8'(lo + $urandom_range(5));
                        pixel_q.push_back({alpha, c0, c1, c2});
                    end
                    8: begin
                        // grey
                        c0 = 8'($urandom);
                        pixel_q.push_back({alpha, c0, c0, c0});
                    end
                    9: begin
                        // two channels share the maximum
                        m    = $urandom_range(1, 255);
                        c0   = 8'(m);
                        c1   = 8'($urandom_range(m));
                        pick = $urandom_range(2);
                        if (pick == 0)
                            pixel_q.push_back({alpha, c0, c0, c1});
                        else if (pick == 1)
                            pixel_q.push_back({alpha, c1, c0, c0});
                        else
                            pixel_q.push_back({alpha, c0, c1, c0});
                    end
                    default: begin
                        pixel_q.push_back($urandom);
                    end
                endcase
            end
            if (ph == 3)
                hold_go = 1'b1;
        end

        if (err_cnt == 0 && rotated_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
